// ===== hdl/text_terminal_char_buffer_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the text terminal character buffer
// Clocked concurrent assertions with an asynchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_CHAR_BUFFER_CORE_ASSERT_SVH
`define TEXT_TERMINAL_CHAR_BUFFER_CORE_ASSERT_SVH

// Checks a property at every rising edge outside reset.
`define TTCB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Checks that a condition is followed by a property on the next edge.
`define TTCB_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== hdl/ttcb_pkg.sv =====
// ---------------------------------------------------------------------------
// ttcb_pkg
// Types and constants shared by the text terminal character buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package ttcb_pkg;

	localparam logic [1:0] OP_PUT    = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_SETCUR = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] REG_COLUMNS      = 2'd0;
	localparam logic [1:0] REG_ROWS         = 2'd1;
	localparam logic [1:0] REG_VISIBLE_ROWS = 2'd2;

	localparam logic [6:0] RST_COLUMNS      = 7'd35;
	localparam logic [5:0] RST_ROWS         = 6'd30;
	localparam logic [5:0] RST_VISIBLE_ROWS = 6'd14;

	localparam logic [7:0] CHAR_SPACE      = 8'd32;
	localparam logic [7:0] CHAR_LAST_PRINT = 8'd126;
	localparam logic [7:0] CHAR_LF         = 8'd10;
	localparam logic [7:0] CHAR_CR         = 8'd13;
	localparam logic [7:0] CHAR_TAB        = 8'd9;

	localparam logic [2:0] TAB_STEP = 3'd4;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] char_code;
		logic [5:0] col_arg;
		logic [4:0] row_arg;
		logic [4:0] view_start;
	} cmd_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [5:0] cursor_col;
		logic [4:0] cursor_row;
		logic [4:0] max_row;
		logic [4:0] view_start_used;
		logic       status;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hdl/ttcb_ram.sv =====
// ---------------------------------------------------------------------------
// ttcb_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module ttcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/text_terminal_char_buffer_core.sv =====
// ---------------------------------------------------------------------------
// text_terminal_char_buffer_core
// Character terminal engine with cursor, wrap, scroll and clamped view reads.
// ---------------------------------------------------------------------------
// One request is worked on at a time by a sequencer around a character RAM
// with one write port and one registered read port. CR, LF without scroll and
// set cursor go from decode straight to the finish step, a printable byte
// passes through the print step and a read through read steps A, B and C; a
// TAB adds a print step for each space after the first. A scroll walks the
// RAM one read and one write per cell, moving each row up, then blanks the
// last row; a clear writes rows*columns cells. The next request can be taken
// in the cycle after the result is raised; a result that is still held back
// keeps the sequencer in its final step. After reset a clearing pass over all
// MAX_ROWS*MAX_COLS cells fills the store with spaces before the first
// request is taken. Configuration writes are taken in any cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module text_terminal_char_buffer_core #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire ttcb_pkg::cmd_t  cmd,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output ttcb_pkg::rsp_t       rsp,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [6:0]      cfg_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
	localparam logic [AW-1:0] COL_STRIDE = AW'(MAX_COLS);
	localparam logic [6:0] COLS_CAP = (MAX_COLS > 127) ? 7'd127 : 7'(MAX_COLS);
	localparam logic [5:0] ROWS_CAP = (MAX_ROWS > 63) ? 6'd63 : 6'(MAX_ROWS);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_PRINT,
		ST_SCROLL_RD,
		ST_SCROLL_WR,
		ST_BLANK,
		ST_CLEAR,
		ST_READ_A,
		ST_READ_B,
		ST_READ_C,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		CELL_MEM,
		CELL_LF,
		CELL_SPACE
	} cell_sel_t;

	state_t         state_q;
	ttcb_pkg::cmd_t cmd_q;
	ttcb_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;
	logic [6:0]     cols_q;
	logic [5:0]     rows_q;
	logic [5:0]     vis_rows_q;
	logic [6:0]     cur_col_q;
	logic [5:0]     cur_row_q;
	logic [5:0]     used_q;
	logic [6:0]     walk_col_q;
	logic [5:0]     walk_row_q;
	logic [AW-1:0]  init_addr_q;
	logic [7:0]     ch_q;
	logic [2:0]     tab_rem_q;
	logic           from_print_q;
	logic [4:0]     vstart_q;
	logic [7:0]     cell_q;
	logic           status_q;
	cell_sel_t      cell_sel_q;

	logic [6:0]    nc;
	logic [5:0]    nr;
	logic [5:0]    vis;
	logic          cur_ok;
	logic [6:0]    col_next;
	logic [5:0]    row_next;
	logic [6:0]    walk_col_next;
	logic [5:0]    walk_row_next;
	logic [6:0]    used_p1;
	logic [6:0]    lim;
	logic [5:0]    view_row;
	logic          in_view;
	logic          rsp_load;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	function automatic logic [AW-1:0] addr_of(input logic [5:0] row, input logic [6:0] col);
		return AW'(AW'(row) * COL_STRIDE) + AW'(col);
	endfunction

	always_comb begin
		if (cols_q == 7'd0) begin
			nc = 7'd1;
		end else if (cols_q > COLS_CAP) begin
			nc = COLS_CAP;
		end else begin
			nc = cols_q;
		end
		if (rows_q == 6'd0) begin
			nr = 6'd1;
		end else if (rows_q > ROWS_CAP) begin
			nr = ROWS_CAP;
		end else begin
			nr = rows_q;
		end
		if (vis_rows_q == 6'd0 || vis_rows_q >= nr) begin
			vis = nr;
		end else begin
			vis = vis_rows_q;
		end
		cur_ok        = (cur_col_q < nc) && (cur_row_q < nr);
		col_next      = cur_col_q + 7'd1;
		row_next      = cur_row_q + 6'd1;
		walk_col_next = walk_col_q + 7'd1;
		walk_row_next = walk_row_q + 6'd1;
		used_p1       = {1'b0, used_q} + 7'd1;
		lim           = used_p1 - {1'b0, vis};
		view_row      = {1'b0, vstart_q} + {1'b0, cmd_q.row_arg};
		in_view       = ({1'b0, cmd_q.row_arg} < vis) && (view_row < nr);
		rsp_load      = (state_q == ST_FINISH) && (!rsp_valid_q || !rsp_stall);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_of(walk_row_q, walk_col_q);
		ram_wdata = ttcb_pkg::CHAR_SPACE;
		ram_raddr = addr_of(walk_row_q, walk_col_q);
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_addr_q;
			end
			ST_PRINT: begin
				ram_we    = cur_ok;
				ram_waddr = addr_of(cur_row_q, cur_col_q);
				ram_wdata = ch_q;
			end
			ST_SCROLL_WR: begin
				ram_we    = 1'b1;
				ram_waddr = addr_of(walk_row_q - 6'd1, walk_col_q);
				ram_wdata = ram_rdata;
			end
			ST_BLANK: begin
				ram_we    = 1'b1;
				ram_waddr = addr_of(nr - 6'd1, walk_col_q);
			end
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_READ_B: begin
				ram_raddr = addr_of(view_row, {1'b0, cmd_q.col_arg});
			end
			default: begin
			end
		endcase
	end

	ttcb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			cmd_q        <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
			cols_q       <= ttcb_pkg::RST_COLUMNS;
			rows_q       <= ttcb_pkg::RST_ROWS;
			vis_rows_q   <= ttcb_pkg::RST_VISIBLE_ROWS;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			used_q       <= '0;
			walk_col_q   <= '0;
			walk_row_q   <= '0;
			init_addr_q  <= '0;
			ch_q         <= '0;
			tab_rem_q    <= '0;
			from_print_q <= 1'b0;
			vstart_q     <= '0;
			cell_q       <= '0;
			status_q     <= 1'b0;
			cell_sel_q   <= CELL_SPACE;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ttcb_pkg::REG_COLUMNS:      cols_q <= cfg_data;
					ttcb_pkg::REG_ROWS:         rows_q <= cfg_data[5:0];
					ttcb_pkg::REG_VISIBLE_ROWS: vis_rows_q <= cfg_data[5:0];
					default: begin
					end
				endcase
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					init_addr_q <= init_addr_q + AW'(1);
					if (init_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q    <= cmd;
						cell_q   <= '0;
						vstart_q <= '0;
						status_q <= 1'b0;
						state_q  <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					walk_col_q   <= '0;
					from_print_q <= 1'b0;
					case (cmd_q.opcode)
						ttcb_pkg::OP_PUT: begin
							if (!cur_ok) begin
								state_q <= ST_FINISH;
							end else if (cmd_q.char_code == ttcb_pkg::CHAR_LF) begin
								cur_col_q <= '0;
								if (row_next >= nr) begin
									walk_row_q <= 6'd1;
									state_q    <= (nr == 6'd1) ? ST_BLANK : ST_SCROLL_RD;
								end else begin
									cur_row_q <= row_next;
									state_q   <= ST_FINISH;
								end
							end else if (cmd_q.char_code == ttcb_pkg::CHAR_CR) begin
								cur_col_q <= '0;
								state_q   <= ST_FINISH;
							end else if (cmd_q.char_code == ttcb_pkg::CHAR_TAB) begin
								ch_q      <= ttcb_pkg::CHAR_SPACE;
								tab_rem_q <= ttcb_pkg::TAB_STEP - {1'b0, cur_col_q[1:0]};
								state_q   <= ST_PRINT;
							end else if (cmd_q.char_code inside
									{[ttcb_pkg::CHAR_SPACE:ttcb_pkg::CHAR_LAST_PRINT]}) begin
								ch_q      <= cmd_q.char_code;
								tab_rem_q <= 3'd1;
								state_q   <= ST_PRINT;
							end else begin
								state_q <= ST_FINISH;
							end
						end
						ttcb_pkg::OP_CLEAR: begin
							cur_col_q  <= '0;
							cur_row_q  <= '0;
							used_q     <= '0;
							walk_row_q <= '0;
							state_q    <= ST_CLEAR;
						end
						ttcb_pkg::OP_SETCUR: begin
							if (({1'b0, cmd_q.col_arg} < nc) && ({1'b0, cmd_q.row_arg} < nr)) begin
								cur_col_q <= {1'b0, cmd_q.col_arg};
								cur_row_q <= {1'b0, cmd_q.row_arg};
							end else begin
								status_q <= 1'b1;
							end
							state_q <= ST_FINISH;
						end
						default: begin
							state_q <= ST_READ_A;
						end
					endcase
				end
				ST_PRINT: begin
					if (!cur_ok) begin
						state_q <= ST_FINISH;
					end else begin
						tab_rem_q <= tab_rem_q - 3'd1;
						if (col_next >= nc) begin
							cur_col_q <= '0;
							if (row_next >= nr) begin
								from_print_q <= 1'b1;
								walk_col_q   <= '0;
								walk_row_q   <= 6'd1;
								state_q      <= (nr == 6'd1) ? ST_BLANK : ST_SCROLL_RD;
							end else begin
								cur_row_q <= row_next;
								if (row_next > used_q) begin
									used_q <= row_next;
								end
								state_q <= (tab_rem_q == 3'd1) ? ST_FINISH : ST_PRINT;
							end
						end else begin
							cur_col_q <= col_next;
							if (cur_row_q > used_q) begin
								used_q <= cur_row_q;
							end
							state_q <= (tab_rem_q == 3'd1) ? ST_FINISH : ST_PRINT;
						end
					end
				end
				ST_SCROLL_RD: begin
					state_q <= ST_SCROLL_WR;
				end
				ST_SCROLL_WR: begin
					if (walk_col_next >= nc) begin
						walk_col_q <= '0;
						walk_row_q <= walk_row_next;
						state_q    <= (walk_row_next >= nr) ? ST_BLANK : ST_SCROLL_RD;
					end else begin
						walk_col_q <= walk_col_next;
						state_q    <= ST_SCROLL_RD;
					end
				end
				ST_BLANK: begin
					walk_col_q <= walk_col_next;
					if (walk_col_next >= nc) begin
						cur_row_q <= nr - 6'd1;
						cur_col_q <= '0;
						if (from_print_q && (nr - 6'd1 > used_q)) begin
							used_q <= nr - 6'd1;
						end
						if (from_print_q && tab_rem_q != 3'd0) begin
							state_q <= ST_PRINT;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_CLEAR: begin
					if (walk_col_next >= nc) begin
						walk_col_q <= '0;
						walk_row_q <= walk_row_next;
						if (walk_row_next >= nr) begin
							state_q <= ST_FINISH;
						end
					end else begin
						walk_col_q <= walk_col_next;
					end
				end
				ST_READ_A: begin
					if (used_p1 <= {1'b0, vis}) begin
						vstart_q <= '0;
					end else if ({2'b00, cmd_q.view_start} > lim) begin
						vstart_q <= lim[4:0];
					end else begin
						vstart_q <= cmd_q.view_start;
					end
					state_q <= ST_READ_B;
				end
				ST_READ_B: begin
					if (!in_view) begin
						cell_sel_q <= CELL_SPACE;
					end else if ({1'b0, cmd_q.col_arg} < nc) begin
						cell_sel_q <= CELL_MEM;
					end else if ({1'b0, cmd_q.col_arg} == nc) begin
						cell_sel_q <= CELL_LF;
					end else begin
						cell_sel_q <= CELL_SPACE;
					end
					state_q <= ST_READ_C;
				end
				ST_READ_C: begin
					case (cell_sel_q)
						CELL_MEM: cell_q <= ram_rdata;
						CELL_LF:  cell_q <= ttcb_pkg::CHAR_LF;
						default:  cell_q <= ttcb_pkg::CHAR_SPACE;
					endcase
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (rsp_load) begin
						rsp_q.cell_char       <= cell_q;
						rsp_q.cursor_col      <= cur_col_q[5:0];
						rsp_q.cursor_row      <= cur_row_q[4:0];
						rsp_q.max_row         <= used_q[4:0];
						rsp_q.view_start_used <= vstart_q;
						rsp_q.status          <= status_q;
						state_q               <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

`include "text_terminal_char_buffer_core_assert.svh"

	`TTCB_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall,
		"Sequencer took a request but did not go busy")
	`TTCB_ASSERT(a_rsp_from_finish, clk, arst_n, $rose(rsp_valid) |-> $past(state_q == ST_FINISH),
		"Response raised outside the finish step")
	`TTCB_ASSERT(a_no_rsp_in_init, clk, arst_n, (state_q == ST_INIT) |-> !rsp_valid_q,
		"Response pending during the clearing pass")
	`TTCB_ASSERT(a_we_in_write_step, clk, arst_n, ram_we |-> (state_q == ST_INIT ||
		state_q == ST_PRINT || state_q == ST_SCROLL_WR || state_q == ST_BLANK ||
		state_q == ST_CLEAR), "Store written outside a write step")

endmodule

`default_nettype wire
